// ----- hdl/rcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// rcsg_pkg
// Shared constants, codes and controller/datapath types for the raycast
// column span generator.
// ----------------------------------------------------------------------------
package rcsg_pkg;

    // Screen geometry
    localparam int SCREEN_HEIGHT = 512;

    // Fixed field widths
    localparam int CFG_W   = 11;
    localparam int RGB_W   = 24;
    localparam int DIST_W  = 24;
    localparam int TX_W    = 10;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 11;
    localparam int RGN_W   = 2;
    localparam int TIDX_W  = 2;
    localparam int RGBA_W  = 32;
    localparam int CIDX_W  = 4;
    localparam int CDATA_W = 24;

    // Derived widths
    localparam int HGT_W     = $clog2(SCREEN_HEIGHT + 1);
    localparam int RCNT_W    = $clog2(SCREEN_HEIGHT);
    localparam int TH_MAX    = 1024;
    localparam int TH_W      = $clog2(TH_MAX + 1);
    localparam int ACC_W     = RCNT_W + TH_W;
    localparam int NUM_SCALE = 2 * SCREEN_HEIGHT * 256;
    localparam int NUM_W     = $clog2(NUM_SCALE) + CFG_W;
    localparam int DEN_W     = DIST_W + 2;
    localparam int DCNT_W    = $clog2(NUM_W + 1);
    localparam int TY_MAX    = 1023;

    // Fill alpha for ceiling and floor pixels
    localparam logic [7:0] ALPHA_BYTE = 8'd155;

    // Config register indexes
    localparam logic [CIDX_W-1:0] CFG_CELL_SIZE  = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_TEX_HEIGHT = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_CEILING    = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_FLOOR      = 4'd3;

    // Config reset values
    localparam logic [CFG_W-1:0] CELL_SIZE_RST  = 11'd64;
    localparam logic [CFG_W-1:0] TEX_HEIGHT_RST = 11'd64;

    // Pixel region codes
    localparam logic [RGN_W-1:0] RGN_CEILING = 2'd0;
    localparam logic [RGN_W-1:0] RGN_WALL    = 2'd1;
    localparam logic [RGN_W-1:0] RGN_FLOOR   = 2'd2;

    // Texture selection codes
    localparam logic [TIDX_W-1:0] TEX_Y_NEG = 2'd0;
    localparam logic [TIDX_W-1:0] TEX_Y_POS = 2'd1;
    localparam logic [TIDX_W-1:0] TEX_X_NEG = 2'd2;
    localparam logic [TIDX_W-1:0] TEX_X_POS = 2'd3;

    // Input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDIV,
        ST_GEOM,
        ST_TDIV,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic latch_col;
        logic load_h_full;
        logic start_hdiv;
        logic load_h_div;
        logic load_geom;
        logic start_tdiv;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic op;
        logic dist_zero;
        logic active;
        logic wall_row;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/raycast_column_span_generator.sv -----
// Column start: input stalls while the divider projects a nonzero distance; a zero distance skips the divider.
// Ceiling/floor pixel: waits in the emit state for a free output register, then is registered at the output.
// Wall pixel: the texel row first comes from the shared radix-2 divider.
// Reset is synchronous, active low: config returns to defaults, no column is active.
// ----------------------------------------------------------------------------
// raycast_column_span_generator
// Emits one screen column of a textured-wall raycaster, one pixel per
// pixel request, after a column-start transaction sets up the wall span.
// ----------------------------------------------------------------------------
module raycast_column_span_generator
    import rcsg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config port
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CDATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_op,
    input  logic [DIST_W-1:0]   i_distance,
    input  logic                i_hit_side,
    input  logic                i_dir_x_negative,
    input  logic                i_dir_y_negative,
    input  logic [TX_W-1:0]     i_texel_column,
    input  logic [COL_W-1:0]    i_screen_column,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [COL_W-1:0]    o_out_column,
    output logic [ROW_W-1:0]    o_out_row,
    output logic [RGN_W-1:0]    o_region,
    output logic [TIDX_W-1:0]   o_texture_index,
    output logic [TX_W-1:0]     o_texel_x,
    output logic [TX_W-1:0]     o_texel_y,
    output logic [RGBA_W-1:0]   o_pixel_rgba,
    output logic                o_last_row
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    rcsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath
    rcsg_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_op),
        .i_distance       (i_distance),
        .i_hit_side       (i_hit_side),
        .i_dir_x_negative (i_dir_x_negative),
        .i_dir_y_negative (i_dir_y_negative),
        .i_texel_column   (i_texel_column),
        .i_screen_column  (i_screen_column),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_column     (o_out_column),
        .o_out_row        (o_out_row),
        .o_region         (o_region),
        .o_texture_index  (o_texture_index),
        .o_texel_x        (o_texel_x),
        .o_texel_y        (o_texel_y),
        .o_pixel_rgba     (o_pixel_rgba),
        .o_last_row       (o_last_row)
    );

endmodule

// ----- hdl/rcsg_div.sv -----
// ----------------------------------------------------------------------------
// rcsg_div
// Radix-2 restoring divider, one quotient bit per cycle. Shared between the
// wall height projection and the texel row lookup.
// ----------------------------------------------------------------------------
module rcsg_div
    import rcsg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_shift;
    logic [DEN_W:0]    w_diff;
    logic              w_bit;
    logic [DEN_W-1:0]  n_rem;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_bit   = ~w_diff[DEN_W];
        n_rem   = w_bit ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
    end

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], w_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hdl/rcsg_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcsg_ctrl
// Sequencer: accepts one transaction at a time, runs the divider for column
// setup and wall texels, and hands pixels to the output register.
// ----------------------------------------------------------------------------
module rcsg_ctrl
    import rcsg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.op == OP_START) begin
                        o_cmd.latch_col = 1'b1;
                        if (i_status.dist_zero) begin
                            o_cmd.load_h_full = 1'b1;
                            n_state           = ST_GEOM;
                        end else begin
                            o_cmd.start_hdiv = 1'b1;
                            n_state          = ST_HDIV;
                        end
                    end else if (i_status.active) begin
                        if (i_status.wall_row) begin
                            o_cmd.start_tdiv = 1'b1;
                            n_state          = ST_TDIV;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_HDIV: begin
                if (i_status.div_done) begin
                    o_cmd.load_h_div = 1'b1;
                    n_state          = ST_GEOM;
                end
            end
            ST_GEOM: begin
                o_cmd.load_geom = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_TDIV: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/rcsg_dpath.sv -----
// ----------------------------------------------------------------------------
// rcsg_dpath
// Datapath: config registers, column state, wall geometry, texel
// accumulator, shared divider and the output register.
// ----------------------------------------------------------------------------
module rcsg_dpath
    import rcsg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config port
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CDATA_W-1:0]  i_cfg_data,
    // input payload
    input  logic                i_op,
    input  logic [DIST_W-1:0]   i_distance,
    input  logic                i_hit_side,
    input  logic                i_dir_x_negative,
    input  logic                i_dir_y_negative,
    input  logic [TX_W-1:0]     i_texel_column,
    input  logic [COL_W-1:0]    i_screen_column,
    // control
    input  t_cmd                i_cmd,
    output t_status             o_status,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [COL_W-1:0]    o_out_column,
    output logic [ROW_W-1:0]    o_out_row,
    output logic [RGN_W-1:0]    o_region,
    output logic [TIDX_W-1:0]   o_texture_index,
    output logic [TX_W-1:0]     o_texel_x,
    output logic [TX_W-1:0]     o_texel_y,
    output logic [RGBA_W-1:0]   o_pixel_rgba,
    output logic                o_last_row
);

    // Config registers
    logic [CFG_W-1:0]  r_cell_size;
    logic [CFG_W-1:0]  r_tex_height;
    logic [RGB_W-1:0]  r_ceiling_rgb;
    logic [RGB_W-1:0]  r_floor_rgb;

    // Column state
    logic              r_active;
    logic [COL_W-1:0]  r_column_x;
    logic [HGT_W-1:0]  r_height;
    logic [HGT_W-1:0]  r_top;
    logic [HGT_W-1:0]  r_bottom;
    logic [RCNT_W-1:0] r_row;
    logic [ACC_W-1:0]  r_acc;
    logic [TIDX_W-1:0] r_texture;
    logic [TX_W-1:0]   r_texel_x;

    // Output register
    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_column;
    logic [ROW_W-1:0]  r_out_row;
    logic [RGN_W-1:0]  r_region;
    logic [TIDX_W-1:0] r_out_texture;
    logic [TX_W-1:0]   r_out_texel_x;
    logic [TX_W-1:0]   r_out_texel_y;
    logic [RGBA_W-1:0] r_out_rgba;
    logic              r_last_row;

    logic              w_div_start;
    logic [NUM_W-1:0]  w_dividend;
    logic [DEN_W-1:0]  w_divisor;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quo;

    logic [NUM_W-1:0]  w_num;
    logic [DEN_W-1:0]  w_den3;
    logic [HGT_W-1:0]  w_h_clamp;
    logic [HGT_W-1:0]  w_top;
    logic [HGT_W:0]    w_bot_sum;
    logic [HGT_W-1:0]  w_bottom;
    logic [HGT_W-1:0]  w_row_ext;
    logic              w_ceil_row;
    logic              w_wall_row;
    logic              w_last;
    logic [TH_W-1:0]   w_th;
    logic [TX_W-1:0]   w_texel_y;
    logic [TIDX_W-1:0] w_texture;

    // Divider operands: height projection or texel row
    always_comb begin
        w_num       = NUM_W'(r_cell_size) * NUM_W'(NUM_SCALE);
        w_den3      = DEN_W'(i_distance) + (DEN_W'(i_distance) << 1);
        w_div_start = i_cmd.start_hdiv | i_cmd.start_tdiv;
        if (i_cmd.start_hdiv) begin
            w_dividend = w_num;
            w_divisor  = w_den3;
        end else begin
            w_dividend = NUM_W'(r_acc);
            w_divisor  = DEN_W'(r_height);
        end
    end

    rcsg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Height clamp and wall span
    always_comb begin
        w_h_clamp = (w_quo > NUM_W'(SCREEN_HEIGHT)) ? HGT_W'(SCREEN_HEIGHT)
                                                    : w_quo[HGT_W-1:0];
        w_top     = (HGT_W'(SCREEN_HEIGHT) - r_height) >> 1;
        w_bot_sum = {1'b0, w_top} + {1'b0, r_height};
        w_bottom  = (w_bot_sum >= (HGT_W+1)'(SCREEN_HEIGHT))
                    ? HGT_W'(SCREEN_HEIGHT - 1) : w_bot_sum[HGT_W-1:0];
    end

    // Texture pick for the new column
    always_comb begin
        if (!i_hit_side) begin
            w_texture = i_dir_x_negative ? TEX_X_NEG : TEX_X_POS;
        end else begin
            w_texture = i_dir_y_negative ? TEX_Y_NEG : TEX_Y_POS;
        end
    end

    // Current row classification
    always_comb begin
        w_row_ext  = HGT_W'(r_row);
        w_ceil_row = (w_row_ext < r_top);
        w_wall_row = !w_ceil_row && (w_row_ext < r_bottom);
        w_last     = (r_row == RCNT_W'(SCREEN_HEIGHT - 1));
        w_th       = (r_tex_height > CFG_W'(TH_MAX)) ? TH_W'(TH_MAX)
                                                     : TH_W'(r_tex_height);
        w_texel_y  = (w_quo > NUM_W'(TY_MAX)) ? TX_W'(TY_MAX) : w_quo[TX_W-1:0];
    end

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size   <= CELL_SIZE_RST;
            r_tex_height  <= TEX_HEIGHT_RST;
            r_ceiling_rgb <= '0;
            r_floor_rgb   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CELL_SIZE:  r_cell_size   <= i_cfg_data[CFG_W-1:0];
                CFG_TEX_HEIGHT: r_tex_height  <= i_cfg_data[CFG_W-1:0];
                CFG_CEILING:    r_ceiling_rgb <= i_cfg_data[RGB_W-1:0];
                CFG_FLOOR:      r_floor_rgb   <= i_cfg_data[RGB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_column_x <= '0;
            r_height   <= '0;
            r_top      <= '0;
            r_bottom   <= '0;
            r_row      <= '0;
            r_acc      <= '0;
            r_texture  <= '0;
            r_texel_x  <= '0;
        end else begin
            if (i_cmd.latch_col) begin
                r_active   <= 1'b1;
                r_column_x <= i_screen_column;
                r_texture  <= w_texture;
                r_texel_x  <= i_texel_column;
                r_row      <= '0;
                r_acc      <= '0;
            end
            if (i_cmd.load_h_full) begin
                r_height <= HGT_W'(SCREEN_HEIGHT);
            end
            if (i_cmd.load_h_div) begin
                r_height <= w_h_clamp;
            end
            if (i_cmd.load_geom) begin
                r_top    <= w_top;
                r_bottom <= w_bottom;
            end
            if (i_cmd.emit) begin
                if (w_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_row <= r_row + RCNT_W'(1);
                end
                if (w_wall_row) begin
                    r_acc <= r_acc + ACC_W'(w_th);
                end
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_column <= r_column_x;
            r_out_row    <= ROW_W'(r_row);
            r_last_row   <= w_last;
            if (w_wall_row) begin
                r_region      <= RGN_WALL;
                r_out_texture <= r_texture;
                r_out_texel_x <= r_texel_x;
                r_out_texel_y <= w_texel_y;
                r_out_rgba    <= '0;
            end else begin
                r_region      <= w_ceil_row ? RGN_CEILING : RGN_FLOOR;
                r_out_texture <= '0;
                r_out_texel_x <= '0;
                r_out_texel_y <= '0;
                r_out_rgba    <= {(w_ceil_row ? r_ceiling_rgb : r_floor_rgb),
                                  ALPHA_BYTE};
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_status.op        = i_op;
        o_status.dist_zero = (i_distance == '0);
        o_status.active    = r_active;
        o_status.wall_row  = w_wall_row;
        o_status.div_done  = w_div_done;
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_column    = r_out_column;
    assign o_out_row       = r_out_row;
    assign o_region        = r_region;
    assign o_texture_index = r_out_texture;
    assign o_texel_x       = r_out_texel_x;
    assign o_texel_y       = r_out_texel_y;
    assign o_pixel_rgba    = r_out_rgba;
    assign o_last_row      = r_last_row;

endmodule

// ----- hdl/rcsg_checker.sv -----
// ----------------------------------------------------------------------------
// rcsg_checker
// Port-level assertions for the raycast column span generator, bound to
// the top level.
// ----------------------------------------------------------------------------
module rcsg_checker
    import rcsg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic                i_op,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic [ROW_W-1:0]    o_out_row,
    input  logic [RGN_W-1:0]    o_region,
    input  logic [TIDX_W-1:0]   o_texture_index,
    input  logic [TX_W-1:0]     o_texel_x,
    input  logic [TX_W-1:0]     o_texel_y,
    input  logic [RGBA_W-1:0]   o_pixel_rgba,
    input  logic                o_last_row
);

    // A stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result transaction keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_row) && $stable(o_region)
            && $stable(o_pixel_rgba) && $stable(o_texel_y))
        else $error("output payload changed while stalled");

    // Column setup keeps the input stalled in the cycle after the start is taken
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op == OP_START |=> o_in_stall)
        else $error("input not stalled during column setup");

    // Only the bottom screen row carries the last-row flag
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_row |-> o_out_row == ROW_W'(SCREEN_HEIGHT - 1))
        else $error("last row flag on wrong row");

    // Ceiling and floor pixels carry a fill color and no texel fields
    a_fill_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_region != RGN_WALL |-> o_texel_x == '0
            && o_texel_y == '0 && o_texture_index == '0
            && o_pixel_rgba[7:0] == ALPHA_BYTE)
        else $error("fill pixel carries texel data");

endmodule

bind raycast_column_span_generator rcsg_checker u_rcsg_checker (.*);

// ----- dv/tb_raycast_column_span_generator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_raycast_column_span_generator
// Self-checking bench for the column span generator. A directed table covers
// the screen edges, both fill colors, all four textures, mid-column restarts
// and pixel requests with no column. Random columns follow, in phases that
// reprogram cell size, texture height and colors, including the masked and
// out-of-range settings. Every pixel is compared with an in-bench model of
// the span logic or with a result pinned in the directed table.
// ----------------------------------------------------------------------------
module tb_raycast_column_span_generator;
    import rcsg_pkg::*;

    localparam int     RAND_ITEMS    = 660;
    localparam int     PHASES        = 6;
    // Column start holds the input with no result while the divider runs
    localparam int     SETTLE_CYCLES = 64;
    // About 1800 transactions, with room for slow ones
    localparam longint CYCLE_LIMIT   = 2000000;
    localparam int     MAX_REPORTS   = 100;

    typedef struct packed {
        logic              op;
        logic [DIST_W-1:0] distance;
        logic              hit_side;
        logic              x_neg;
        logic              y_neg;
        logic [TX_W-1:0]   tex_col;
        logic [COL_W-1:0]  scr_col;
    } t_ray_item;

    localparam int ITEM_W = $bits(t_ray_item);

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [RGN_W-1:0]  region;
        logic [TIDX_W-1:0] tex_idx;
        logic [TX_W-1:0]   tex_x;
        logic [TX_W-1:0]   tex_y;
        logic [RGBA_W-1:0] rgba;
        logic              last;
    } t_pixel;

    // One table row: a transaction, a repeat count and an optional pinned result
    typedef struct {
        t_ray_item item;
        int        reps;
        bit        pinned;
        bit        pin_has;
        t_pixel    pin_px;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CIDX_W-1:0]   i_cfg_index;
    logic [CDATA_W-1:0]  i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_op;
    logic [DIST_W-1:0]   i_distance;
    logic                i_hit_side;
    logic                i_dir_x_negative;
    logic                i_dir_y_negative;
    logic [TX_W-1:0]     i_texel_column;
    logic [COL_W-1:0]    i_screen_column;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [COL_W-1:0]    o_out_column;
    logic [ROW_W-1:0]    o_out_row;
    logic [RGN_W-1:0]    o_region;
    logic [TIDX_W-1:0]   o_texture_index;
    logic [TX_W-1:0]     o_texel_x;
    logic [TX_W-1:0]     o_texel_y;
    logic [RGBA_W-1:0]   o_pixel_rgba;
    logic                o_last_row;

    // Pinned result travelling with the driven transaction
    bit     drv_pinned;
    bit     drv_has;
    t_pixel drv_px;

    // Register mirror
    logic [CFG_W-1:0] cell_size_m;
    logic [CFG_W-1:0] tex_height_m;
    logic [RGB_W-1:0] ceiling_m;
    logic [RGB_W-1:0] floor_m;

    // Column state mirror
    logic              col_active;
    logic [COL_W-1:0]  col_x;
    logic [ROW_W-1:0]  wall_top_m;
    logic [ROW_W-1:0]  wall_bot_m;
    logic [ROW_W-1:0]  wall_hgt_m;
    logic [ROW_W-1:0]  row_m;
    logic [20:0]       tex_acc;
    logic [TIDX_W-1:0] tex_sel;
    logic [TX_W-1:0]   tex_col_m;

    t_pixel pixels_due[$];
    int     err_count   = 0;
    longint cycle_count = 0;
    int     burst_left  = 0;
    bit     quiet_phase = 1'b0;

    raycast_column_span_generator i_dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        if (err_count < MAX_REPORTS)
            $display("%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Projected wall height in rows, clamped to the screen
    function automatic logic [ROW_W-1:0] projected_height(input logic [DIST_W-1:0] ray_dist);
        longint unsigned num;
        longint unsigned quo;
        if (ray_dist == '0)
            return ROW_W'(SCREEN_HEIGHT);
        num = 64'(2 * SCREEN_HEIGHT * 256) * 64'(cell_size_m);
        quo = num / (64'd3 * 64'(ray_dist));
        if (quo > 64'(SCREEN_HEIGHT))
            quo = 64'(SCREEN_HEIGHT);
        return ROW_W'(quo);
    endfunction

    // Advance the column mirror by one transaction; returns 1 when a pixel is due
    function automatic bit next_pixel(input t_ray_item it, output t_pixel px);
        logic [ROW_W-1:0] row;
        logic [20:0]      quo;
        logic [CFG_W-1:0] th;
        px = '0;
        if (it.op == OP_START) begin
            wall_hgt_m = projected_height(it.distance);
            wall_top_m = (ROW_W'(SCREEN_HEIGHT) - wall_hgt_m) >> 1;
            wall_bot_m = wall_top_m + wall_hgt_m;
            if (wall_bot_m >= ROW_W'(SCREEN_HEIGHT))
                wall_bot_m = ROW_W'(SCREEN_HEIGHT - 1);
            if (!it.hit_side)
                tex_sel = it.x_neg ? TEX_X_NEG : TEX_X_POS;
            else
                tex_sel = it.y_neg ? TEX_Y_NEG : TEX_Y_POS;
            tex_col_m  = it.tex_col;
            col_x      = it.scr_col;
            row_m      = '0;
            tex_acc    = '0;
            col_active = 1'b1;
            return 1'b0;
        end
        if (!col_active)
            return 1'b0;

        row    = row_m;
        px.col = col_x;
        px.row = row;
        if (row < wall_top_m) begin
            px.region = RGN_CEILING;
            px.rgba   = {ceiling_m, ALPHA_BYTE};
        end else if (row < wall_bot_m) begin
            th = (tex_height_m > CFG_W'(TH_MAX)) ? CFG_W'(TH_MAX) : tex_height_m;
            quo = (wall_hgt_m != '0) ? tex_acc / wall_hgt_m : '0;
            px.region  = RGN_WALL;
            px.tex_idx = tex_sel;
            px.tex_x   = tex_col_m;
            px.tex_y   = (quo > 21'(TY_MAX)) ? TX_W'(TY_MAX) : quo[TX_W-1:0];
            tex_acc    = tex_acc + 21'(th);
        end else begin
            px.region = RGN_FLOOR;
            px.rgba   = {floor_m, ALPHA_BYTE};
        end

        px.last = (row >= ROW_W'(SCREEN_HEIGHT - 1));
        if (px.last)
            col_active = 1'b0;
        else
            row_m = row + ROW_W'(1);
        return 1'b1;
    endfunction

    // Monitor: check the output transaction, then predict the input one
    always @(posedge i_clk) begin : monitor
        t_pixel    got;
        t_pixel    want;
        t_pixel    pred;
        t_ray_item seen;
        bit        emits;
        cycle_count = cycle_count + 1;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_out_column, o_out_row, o_region, o_texture_index,
                       o_texel_x, o_texel_y, o_pixel_rgba, o_last_row};
                if (pixels_due.size() == 0) begin
                    report("pixel with nothing pending, row", got.row, 0);
                end else begin
                    want = pixels_due.pop_front();
                    if (got.col !== want.col)         report("out_column", got.col, want.col);
                    if (got.row !== want.row)         report("out_row", got.row, want.row);
                    if (got.region !== want.region)   report("region", got.region, want.region);
                    if (got.tex_idx !== want.tex_idx)
                        report("texture_index", got.tex_idx, want.tex_idx);
                    if (got.tex_x !== want.tex_x)     report("texel_x", got.tex_x, want.tex_x);
                    if (got.tex_y !== want.tex_y)     report("texel_y", got.tex_y, want.tex_y);
                    if (got.rgba !== want.rgba)       report("pixel_rgba", got.rgba, want.rgba);
                    if (got.last !== want.last)       report("last_row", got.last, want.last);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                seen = {i_op, i_distance, i_hit_side, i_dir_x_negative, i_dir_y_negative,
                        i_texel_column, i_screen_column};
                emits = next_pixel(seen, pred);
                if (drv_pinned) begin
                    if (drv_has)
                        pixels_due.push_back(drv_px);
                end else if (emits) begin
                    pixels_due.push_back(pred);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // Receiver stall pattern: quiet, light, heavy and blocky stretches
    initial begin : out_stall_pattern
        int mode;
        int len;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(16, 256);
            for (int c = 0; c < len; c++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 3) == 0);
                    2:       i_out_stall = ($urandom_range(0, 9) < 7);
                    default: i_out_stall = ((c % 24) < 12);
                endcase
            end
        end
    end

    // Send one transaction, in bursts separated by random gaps (no gaps in quiet phases)
    task automatic send(input t_ray_item it, input bit pinned, input bit has,
                        input t_pixel px);
        int gap;
        if (burst_left == 0) begin
            gap = quiet_phase ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        {i_op, i_distance, i_hit_side, i_dir_x_negative, i_dir_y_negative,
         i_texel_column, i_screen_column} = it;
        drv_pinned = pinned;
        drv_has    = has;
        drv_px     = px;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop sending until every pending pixel has arrived, then let a start settle
    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        case (idx)
            CFG_CELL_SIZE:  cell_size_m  = data[CFG_W-1:0];
            CFG_TEX_HEIGHT: tex_height_m = data[CFG_W-1:0];
            CFG_CEILING:    ceiling_m    = data[RGB_W-1:0];
            CFG_FLOOR:      floor_m      = data[RGB_W-1:0];
            default: ;
        endcase
    endtask

    function automatic t_stim_row mk_row(input logic op, input logic [DIST_W-1:0] ray_dist,
                                         input logic [2:0] dirs, input logic [TX_W-1:0] tcol,
                                         input logic [COL_W-1:0] scol, input int reps);
        t_stim_row r;
        r.item    = {op, ray_dist, dirs, tcol, scol};
        r.reps    = reps;
        r.pinned  = 1'b0;
        r.pin_has = 1'b0;
        r.pin_px  = '0;
        return r;
    endfunction

    function automatic t_stim_row pin(input t_stim_row r, input bit has, input t_pixel px);
        r.pinned  = 1'b1;
        r.pin_has = has;
        r.pin_px  = px;
        return r;
    endfunction

    initial begin : stimulus
        t_stim_row          tab[$];
        t_ray_item          it;
        logic [CDATA_W-1:0] cs, th, cc, fc;
        int                 sent;
        int                 n;
        int                 pick;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_op             = OP_PIXEL;
        i_distance       = '0;
        i_hit_side       = 1'b0;
        i_dir_x_negative = 1'b0;
        i_dir_y_negative = 1'b0;
        i_texel_column   = '0;
        i_screen_column  = '0;
        drv_pinned       = 1'b0;
        drv_has          = 1'b0;
        drv_px           = '0;

        cell_size_m  = CELL_SIZE_RST;
        tex_height_m = TEX_HEIGHT_RST;
        ceiling_m    = '0;
        floor_m      = '0;
        col_active   = 1'b0;
        col_x        = '0;
        wall_top_m   = '0;
        wall_bot_m   = '0;
        wall_hgt_m   = '0;
        row_m        = '0;
        tex_acc      = '0;
        tex_sel      = '0;
        tex_col_m    = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, reset configuration
        // pixel request with no column
        tab.push_back(pin(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 1), 1'b0, '0));
        // distance zero: full height, top row is wall, bottom row is floor
        tab.push_back(pin(mk_row(OP_START, '0, 3'b001, 10'd1023, 12'd4095, 1), 1'b0, '0));
        tab.push_back(pin(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 1), 1'b1,
                          {12'd4095, 11'd0, RGN_WALL, TEX_X_POS, 10'd1023, 10'd0,
                           32'd0, 1'b0}));
        tab.push_back(mk_row(OP_PIXEL, 24'hFFFFFF, 3'b111, 10'd1023, 12'd4095, 509));
        tab.push_back(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 1));
        tab.push_back(pin(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 1), 1'b1,
                          {12'd4095, 11'd511, RGN_FLOOR, 2'd0, 10'd0, 10'd0,
                           {24'd0, ALPHA_BYTE}, 1'b1}));
        // column already finished
        tab.push_back(pin(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 1), 1'b0, '0));
        // farthest distance: no wall rows at all
        tab.push_back(pin(mk_row(OP_START, 24'hFFFFFF, 3'b110, 10'd0, 12'd0, 1), 1'b0, '0));
        tab.push_back(pin(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 1), 1'b1,
                          {12'd0, 11'd0, RGN_CEILING, 2'd0, 10'd0, 10'd0,
                           {24'd0, ALPHA_BYTE}, 1'b0}));
        tab.push_back(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 40));
        // restart in the middle of a column
        tab.push_back(mk_row(OP_START, 24'd1, 3'b101, 10'd512, 12'd2048, 1));
        tab.push_back(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 4));
        tab.push_back(mk_row(OP_START, 24'h004000, 3'b010, 10'd341, 12'd1234, 1));
        tab.push_back(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 200));
        tab.push_back(mk_row(OP_START, 24'h000100, 3'b111, 10'd77, 12'd9, 1));
        tab.push_back(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 20));
        // short wall around the middle row
        tab.push_back(mk_row(OP_START, 24'h0AAAAA, 3'b000, 10'h2AA, 12'hAAA, 1));
        tab.push_back(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 270));
        // back-to-back column starts
        tab.push_back(mk_row(OP_START, 24'h555555, 3'b100, 10'h155, 12'h555, 1));
        tab.push_back(mk_row(OP_START, 24'h000600, 3'b011, 10'd1, 12'd1, 1));
        tab.push_back(mk_row(OP_PIXEL, '0, 3'b000, '0, '0, 5));

        foreach (tab[r])
            for (int k = 0; k < tab[r].reps; k++)
                send(tab[r].item, tab[r].pinned, tab[r].pin_has, tab[r].pin_px);
        drain();

        // Random columns, one register setting per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    cs = 24'd1;  th = 24'd1;  cc = 24'hFFFFFF; fc = 24'h000000;
                end
                1: begin
                    cs = 24'd1024; th = 24'd1024; cc = 24'h000000; fc = 24'hFFFFFF;
                end
                2: begin
                    // upper bits masked off, texture height clamps to its maximum
                    cs = 24'hFFFFFF; th = 24'hFFFFFF;
                    cc = CDATA_W'($urandom); fc = CDATA_W'($urandom);
                end
                3: begin
                    // zero after masking: wall rows only at distance zero, texel_y stays zero
                    cs = 24'hFFF800; th = 24'h000800;
                    cc = CDATA_W'($urandom); fc = CDATA_W'($urandom);
                end
                default: begin
                    cs = CDATA_W'($urandom_range(1, 1024));
                    th = CDATA_W'($urandom_range(1, 1024));
                    cc = CDATA_W'($urandom); fc = CDATA_W'($urandom);
                end
            endcase
            write_reg(CFG_CELL_SIZE, cs);
            write_reg(CFG_TEX_HEIGHT, th);
            write_reg(CFG_CEILING, cc);
            write_reg(CFG_FLOOR, fc);
            // unmapped index must leave every register alone
            write_reg(CIDX_W'($urandom_range(CFG_FLOOR + 1, (1 << CIDX_W) - 1)),
                      CDATA_W'($urandom));
            @(negedge i_clk);
            i_cfg_we = 1'b0;

            quiet_phase = (ph % 3 == 1);
            sent = 0;
            while (sent < RAND_ITEMS / PHASES) begin
                // stray pixel request before the start
                if ($urandom_range(0, 19) == 0) begin
                    it    = ITEM_W'({$urandom, $urandom});
                    it.op = OP_PIXEL;
                    send(it, 1'b0, 1'b0, '0);
                end

                it    = ITEM_W'({$urandom, $urandom});
                it.op = OP_START;
                case ($urandom_range(0, 9))
                    0:          it.distance = '0;
                    1, 2, 3, 4: it.distance = DIST_W'($urandom_range(1, 24'h003FFF));
                    5, 6, 7:    it.distance = DIST_W'($urandom_range(1, 24'h0FFFFF));
                    default:    it.distance = DIST_W'($urandom);
                endcase
                send(it, 1'b0, 1'b0, '0);
                sent++;
                if ($urandom_range(0, 9) == 0) begin
                    it    = ITEM_W'({$urandom, $urandom});
                    it.op = OP_START;
                    send(it, 1'b0, 1'b0, '0);
                    sent++;
                end

                pick = $urandom_range(0, 19);
                if (pick < 2)
                    n = SCREEN_HEIGHT + $urandom_range(0, 2);
                else if (pick < 7)
                    n = $urandom_range(220, 300);
                else
                    n = $urandom_range(1, 40);
                // keep each phase near its share of the transaction budget
                if (n > RAND_ITEMS / PHASES - sent)
                    n = RAND_ITEMS / PHASES - sent;
                for (int k = 0; k < n; k++) begin
                    it    = ITEM_W'({$urandom, $urandom});
                    it.op = OP_PIXEL;
                    send(it, 1'b0, 1'b0, '0);
                    if (k < SCREEN_HEIGHT)
                        sent++;
                end

                if ($urandom_range(0, 14) == 0)
                    drain();
            end
            drain();
        end

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
